// ===== rtl/oors_pkg.sv =====
// Shared types and constants for the oldest-or-richest service queue.
// Transaction payload structs, table entry layout, scan modes and codes.
// No dependencies.
package oors_pkg;

	localparam int ID_W         = 32;
	localparam int VAL_W        = 16;
	localparam int CAPACITY_DEF = 256;

	// request function codes
	localparam logic [1:0] FUNC_ARRIVE  = 2'd0;
	localparam logic [1:0] FUNC_OLDEST  = 2'd1;
	localparam logic [1:0] FUNC_LARGEST = 2'd2;

	// response status codes
	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_SERVED = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] customer_id;
	} rsp_t;

	// one table slot as held in the memory
	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] value;
	} entry_t;

	// what the scan is looking for
	typedef enum logic [1:0] {
		PICK_FREE    = 2'd0,
		PICK_OLDEST  = 2'd1,
		PICK_LARGEST = 2'd2
	} pick_mode_t;

	typedef struct packed {
		logic       clear;
		logic       sample;
		pick_mode_t mode;
	} pick_ctl_t;

endpackage

// ===== rtl/oors_pick.sv =====
// Scan selector: follows the table read stream and keeps the best slot so far.
// Finds the first free slot, the oldest entry, or the largest value (oldest on tie).
// Depends on oors_pkg.
module oors_pick #(
	parameter int IDX_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oors_pkg::pick_ctl_t           ctl,
	input  oors_pkg::entry_t              entry,
	input  logic [IDX_W-1:0]              idx,
	output logic                          found,
	output logic [IDX_W-1:0]              best_idx,
	output logic [oors_pkg::ID_W-1:0]     best_id
);

	logic                           found_q;
	logic [IDX_W-1:0]               best_idx_q;
	logic [oors_pkg::ID_W-1:0]      best_id_q;
	logic [oors_pkg::VAL_W-1:0]     best_val_q;
	logic                           older;
	logic                           take;

	// candidate comparison
	always_comb begin
		older = entry.id < best_id_q;
		take  = 1'b0;
		unique case (ctl.mode)
			oors_pkg::PICK_FREE: begin
				take = ctl.sample && !entry.valid && !found_q;
			end
			oors_pkg::PICK_OLDEST: begin
				take = ctl.sample && entry.valid && (!found_q || older);
			end
			oors_pkg::PICK_LARGEST: begin
				take = ctl.sample && entry.valid &&
					(!found_q || (entry.value > best_val_q) ||
					 ((entry.value == best_val_q) && older));
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	// found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// best candidate payload
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx;
			best_id_q  <= entry.id;
			best_val_q <= entry.value;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_id  = best_id_q;

endmodule

// ===== rtl/oldest_or_richest_service_queue_top.sv =====
// Oldest-or-richest service queue, top level: table memory and sequencer.
// Serve: the result waits for the full table scan through one read port,
// which reads one slot per cycle into a registered read stage.
// Arrival: the scan stops at the lowest free slot; a refused arrival or a serve on an empty table skips the scan.
// One transaction at a time: the next request is taken the cycle after the result is loaded.
// After reset a clearing pass invalidates every slot while req_ready is held low.
module oldest_or_richest_service_queue_top #(
	parameter int CAPACITY = oors_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  oors_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output oors_pkg::rsp_t rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_WRITE = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               waiting_q;
	logic [oors_pkg::ID_W-1:0]      next_id_q;
	logic [oors_pkg::VAL_W-1:0]     value_q;
	oors_pkg::pick_mode_t           mode_q;
	logic                           scan_done_q;
	oors_pkg::rsp_t                 res_q;
	oors_pkg::rsp_t                 rsp_q;
	logic                           rsp_valid_q;

	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               rd_idx_s1;
	oors_pkg::entry_t               rd_data_s1;

	oors_pkg::entry_t               mem [CAPACITY];

	logic                           accept;
	logic                           rd_en;
	logic                           wr_en;
	logic [IDX_W-1:0]               wr_addr;
	oors_pkg::entry_t               wr_data;
	logic                           full;
	logic                           scan_end;
	logic                           rsp_load;
	oors_pkg::pick_ctl_t            pick_ctl;
	logic                           pick_found;
	logic [IDX_W-1:0]               pick_idx;
	logic [oors_pkg::ID_W-1:0]      pick_id;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (waiting_q == CNT_W'(CAPACITY)) || (next_id_q == '0);
	assign rd_en     = (state_q == S_SCAN) && (cnt_q != CNT_W'(CAPACITY));
	assign scan_end  = (mode_q == oors_pkg::PICK_FREE) ? pick_found : scan_done_q;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	// memory write source: clearing pass or write-back after a scan
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == S_WRITE) begin
			wr_en   = 1'b1;
			wr_addr = pick_idx;
			if (mode_q == oors_pkg::PICK_FREE) begin
				wr_data.valid = 1'b1;
				wr_data.id    = next_id_q;
				wr_data.value = value_q;
			end else begin
				wr_data.valid = 1'b0;
				wr_data.id    = pick_id;
			end
		end
	end

	// table memory; scan and write-back never overlap, so no forwarding needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q[IDX_W-1:0]];
		end
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
	end

	// read pipeline valid and end-of-scan marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			scan_done_q <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			scan_done_q <= (state_q == S_SCAN) && rd_vld_s1 &&
				(rd_idx_s1 == IDX_W'(CAPACITY - 1));
		end
	end

	// selector
	always_comb begin
		pick_ctl.clear  = accept;
		pick_ctl.sample = rd_vld_s1 && (state_q == S_SCAN);
		pick_ctl.mode   = mode_q;
	end

	oors_pick #(
		.IDX_W (IDX_W)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pick_ctl),
		.entry    (rd_data_s1),
		.idx      (rd_idx_s1),
		.found    (pick_found),
		.best_idx (pick_idx),
		.best_id  (pick_id)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cnt_q     <= '0;
			waiting_q <= '0;
			next_id_q <= oors_pkg::ID_W'(1);
			mode_q    <= oors_pkg::PICK_FREE;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(CAPACITY - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						priority if (req.func == oors_pkg::FUNC_ARRIVE) begin
							mode_q <= oors_pkg::PICK_FREE;
							state_q <= full ? S_RESP : S_SCAN;
						end else if (req.func == oors_pkg::FUNC_OLDEST) begin
							mode_q <= oors_pkg::PICK_OLDEST;
							state_q <= (waiting_q == '0) ? S_RESP : S_SCAN;
						end else if (req.func == oors_pkg::FUNC_LARGEST) begin
							mode_q <= oors_pkg::PICK_LARGEST;
							state_q <= (waiting_q == '0) ? S_RESP : S_SCAN;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (mode_q == oors_pkg::PICK_FREE) begin
						next_id_q <= next_id_q + oors_pkg::ID_W'(1);
						waiting_q <= waiting_q + CNT_W'(1);
					end else begin
						waiting_q <= waiting_q - CNT_W'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q               <= req.value;
			res_q.customer_id     <= '0;
			if (req.func == oors_pkg::FUNC_ARRIVE) begin
				res_q.status <= oors_pkg::ST_FULL;
			end else begin
				res_q.status <= oors_pkg::ST_EMPTY;
			end
		end else if (state_q == S_WRITE) begin
			if (mode_q == oors_pkg::PICK_FREE) begin
				res_q.status      <= oors_pkg::ST_STORED;
				res_q.customer_id <= next_id_q;
			end else begin
				res_q.status      <= oors_pkg::ST_SERVED;
				res_q.customer_id <= pick_id;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
